// ===== rtl/core/pkt_dfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer package
// Shared constants and the result word type of the frame deframer.
// ----------------------------------------------------------------------------
package pkt_dfr_pkg;

	localparam int unsigned BYTE_W = 8;

	localparam logic [BYTE_W-1:0] HDR_OFFSET_RST = 8'd17;
	localparam logic [BYTE_W-1:0] SUM_GOOD       = 8'hFF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef struct packed {
		logic              result_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] subsystem;
		logic [BYTE_W-1:0] command_code;
		logic [BYTE_W-1:0] payload_length;
		logic              checksum_ok;
	} res_t;

endpackage

// ===== rtl/core/pkt_dfr_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Received byte channel
// valid/ready channel carrying one buffer byte and its start flag.
// ----------------------------------------------------------------------------
interface pkt_dfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

// ===== rtl/core/pkt_dfr_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// valid/ready channel carrying payload bytes and end of frame verdicts.
// ----------------------------------------------------------------------------
interface pkt_dfr_res_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] subsystem;
	logic [7:0] command_code;
	logic [7:0] payload_length;
	logic       checksum_ok;

	modport source (output valid, result_kind, payload_byte, payload_index, subsystem,
		command_code, payload_length, checksum_ok, input ready);
	modport sink (input valid, result_kind, payload_byte, payload_index, subsystem,
		command_code, payload_length, checksum_ok, output ready);
endinterface

// ===== rtl/core/pkt_dfr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// valid/ready channel carrying the header offset register value.
// ----------------------------------------------------------------------------
interface pkt_dfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_offset;

	modport source (output valid, header_offset, input ready);
	modport sink (input valid, header_offset, output ready);
endinterface

// ===== rtl/core/pkt_dfr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer core
// Frame phase tracking, running sum and result formation for one byte a cycle while acc is high.
// ----------------------------------------------------------------------------
module pkt_dfr_core
	import pkt_dfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              acc,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              frame_start,
	output logic              push,
	output res_t              res
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SUBSYS = 3'd2;
	localparam logic [2:0] PH_CMD    = 3'd3;
	localparam logic [2:0] PH_LEN    = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_CHECK  = 3'd6;

	logic [BYTE_W-1:0] offset_q;
	logic [2:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] cnt_q, cnt_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] subsys_q, subsys_d;
	logic [BYTE_W-1:0] cmd_q, cmd_d;
	logic [BYTE_W-1:0] len_q, len_d;

	always_comb begin
		logic [2:0]        ph;
		logic [BYTE_W-1:0] cnt;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] sum_inc;
		logic [BYTE_W-1:0] cnt_inc;

		ph     = phase_q;
		cnt    = cnt_q;
		sum    = sum_q;
		subsys_d = subsys_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		// start flag restarts the buffer on this very byte
		if (frame_start) begin
			ph       = (offset_q == '0) ? PH_SUBSYS : PH_HEADER;
			cnt      = '0;
			sum      = '0;
			subsys_d = '0;
			cmd_d    = '0;
			len_d    = '0;
		end
		sum_inc = sum + rx_byte;
		cnt_inc = cnt + BYTE_W'(1);

		phase_d = ph;
		cnt_d   = cnt;
		sum_d   = sum;
		push    = 1'b0;
		res     = '0;

		case (ph)
			PH_HEADER: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= offset_q)
					phase_d = PH_SUBSYS;
			end
			PH_SUBSYS: begin
				subsys_d = rx_byte;
				sum_d    = sum_inc;
				phase_d  = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = rx_byte;
				sum_d   = sum_inc;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = sum_inc;
				cnt_d   = '0;
				phase_d = (rx_byte == '0) ? PH_CHECK : PH_DATA;
			end
			PH_DATA: begin
				sum_d             = sum_inc;
				push              = acc;
				res.result_kind   = KIND_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt;
				cnt_d             = cnt_inc;
				if (cnt_inc == len_d)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				sum_d              = sum_inc;
				push               = acc;
				res.result_kind    = KIND_VERDICT;
				res.subsystem      = subsys_d;
				res.command_code   = cmd_d;
				res.payload_length = len_d;
				res.checksum_ok    = (sum_inc == SUM_GOOD);
				phase_d            = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= HDR_OFFSET_RST;
		end else if (cfg_we) begin
			offset_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			sum_q    <= '0;
			subsys_q <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
		end else if (acc) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			sum_q    <= sum_d;
			subsys_q <= subsys_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
		end
	end

endmodule

// ===== rtl/core/pkt_dfr_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output queue
// Two-word queue: output register plus skid entry, so the byte side keeps
// flowing while a result waits.
// ----------------------------------------------------------------------------
module pkt_dfr_outq
	import pkt_dfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output res_t dout
);

	logic [1:0] cnt_q;
	res_t       head_q;
	res_t       skid_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign dout      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case (cnt_q)
				2'd0: if (push) cnt_q <= 2'd1;
				2'd1: begin
					if (push && !pop)
						cnt_q <= 2'd2;
					else if (!push && pop)
						cnt_q <= 2'd0;
				end
				2'd2: if (pop) cnt_q <= 2'd1;
				default: cnt_q <= 2'd0;
			endcase
		end
	end

	// payload entries, no reset
	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: if (push) head_q <= din;
			2'd1: begin
				if (push && pop)
					head_q <= din;
				else if (push)
					skid_q <= din;
			end
			2'd2: if (pop) head_q <= skid_q;
			default: head_q <= head_q;
		endcase
	end

endmodule

// ===== rtl/core/packet_deframer_sum_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet deframer with 8-bit sum check
// Length-prefixed frame deframer: emits payload bytes with index and a final
// verdict with header fields and checksum status.
// ----------------------------------------------------------------------------
// Takes one received word per clock, set by the phase/sum update and the
// two-word output queue; byte_ch.ready drops only while two results wait
// unread. Words that cause no result are taken regardless of how many
// results wait, except when the queue is full. Each word is processed in the
// cycle it is accepted; its payload byte or verdict is visible from the next
// cycle if the queue is empty or its head is read, else it waits in the skid.
// header_offset is written through cfg_ch (always ready); the user must do so
// only while the block is idle, which the block does not enforce. It resets to 17.
module packet_deframer_sum_check
	import pkt_dfr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pkt_dfr_cfg_if.sink      cfg_ch,
	pkt_dfr_byte_if.sink     byte_ch,
	pkt_dfr_res_if.source    result_ch
);

	logic acc;
	logic push;
	logic full;
	res_t res;
	res_t res_out;

	assign cfg_ch.ready  = 1'b1;
	assign byte_ch.ready = !full;
	assign acc           = byte_ch.valid && !full;

	pkt_dfr_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_ch.valid),
		.cfg_data    (cfg_ch.header_offset),
		.acc         (acc),
		.rx_byte     (byte_ch.rx_byte),
		.frame_start (byte_ch.frame_start),
		.push        (push),
		.res         (res)
	);

	pkt_dfr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (res),
		.full      (full),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.dout      (res_out)
	);

	assign result_ch.result_kind    = res_out.result_kind;
	assign result_ch.payload_byte   = res_out.payload_byte;
	assign result_ch.payload_index  = res_out.payload_index;
	assign result_ch.subsystem      = res_out.subsystem;
	assign result_ch.command_code   = res_out.command_code;
	assign result_ch.payload_length = res_out.payload_length;
	assign result_ch.checksum_ok    = res_out.checksum_ok;

endmodule

// ===== rtl/core/pkt_dfr_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the top level ports, bound to the deframer.
// ----------------------------------------------------------------------------
module pkt_dfr_chk
	import pkt_dfr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              result_kind,
	input logic [BYTE_W-1:0] payload_byte,
	input logic [BYTE_W-1:0] payload_index,
	input logic [BYTE_W-1:0] subsystem,
	input logic [BYTE_W-1:0] command_code,
	input logic [BYTE_W-1:0] payload_length,
	input logic              checksum_ok
);

	// byte side only stalls when results are backed up
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("byte side stalled with no result pending");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |->
			subsystem == '0 && command_code == '0 && payload_length == '0 &&
			!checksum_ok && payload_index != 8'hFF)
		else $error("payload word carries verdict fields or bad index");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_VERDICT |->
			payload_byte == '0 && payload_index == '0)
		else $error("verdict word carries payload fields");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(payload_byte) && $stable(payload_index) && $stable(subsystem) &&
			$stable(command_code) && $stable(payload_length) && $stable(checksum_ok))
		else $error("stalled result word changed");

endmodule

bind packet_deframer_sum_check pkt_dfr_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (byte_ch.ready),
	.out_valid      (result_ch.valid),
	.out_ready      (result_ch.ready),
	.result_kind    (result_ch.result_kind),
	.payload_byte   (result_ch.payload_byte),
	.payload_index  (result_ch.payload_index),
	.subsystem      (result_ch.subsystem),
	.command_code   (result_ch.command_code),
	.payload_length (result_ch.payload_length),
	.checksum_ok    (result_ch.checksum_ok)
);

// ===== sim/packet_deframer_sum_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Drives received byte words with random gaps into the deframer. A tracking
// model predicts every payload word and verdict, and each result is checked
// in order. Covers header offsets from 0 to 255, restarts, trailing bytes,
// bad sums and offset changes part way through a header.
// ----------------------------------------------------------------------------
module packet_deframer_sum_check_tb;
	import pkt_dfr_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_WORDS   = 850;

	typedef enum logic [2:0] {
		ST_IDLE, ST_HEADER, ST_SUBSYS, ST_CMD, ST_LEN, ST_DATA, ST_CHECK
	} dfr_state_t;

	logic clk = 1'b0;
	logic arst_n;

	pkt_dfr_cfg_if  cfg_bus ();
	pkt_dfr_byte_if byte_bus ();
	pkt_dfr_res_if  res_bus ();

	packet_deframer_sum_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_ch    (cfg_bus),
		.byte_ch   (byte_bus),
		.result_ch (res_bus)
	);

	always #1 clk = ~clk;

	// tracked copy of the deframer state
	logic [7:0] trk_offset;
	dfr_state_t trk_state;
	logic [7:0] trk_count;
	logic [7:0] trk_sum;
	logic [7:0] trk_sub;
	logic [7:0] trk_cmd;
	logic [7:0] trk_len;

	res_t pending_results[$];

	int fail_count     = 0;
	int words_sent     = 0;
	int payload_seen   = 0;
	int verdicts_seen  = 0;
	int good_verdicts  = 0;
	int settings_used  = 0;
	int idle_cycles    = 0;
	bit tx_steady      = 1'b0;
	bit rx_steady      = 1'b0;

	function automatic void deframe_byte(input logic [7:0] b, input logic s);
		res_t r;
		r = '0;
		if (s) begin
			trk_sum   = '0;
			trk_count = '0;
			trk_sub   = '0;
			trk_cmd   = '0;
			trk_len   = '0;
			trk_state = (trk_offset == 8'd0) ? ST_SUBSYS : ST_HEADER;
		end
		case (trk_state)
			ST_HEADER: begin
				trk_count = trk_count + 8'd1;
				if (trk_count >= trk_offset)
					trk_state = ST_SUBSYS;
			end
			ST_SUBSYS: begin
				trk_sub   = b;
				trk_sum   = trk_sum + b;
				trk_state = ST_CMD;
			end
			ST_CMD: begin
				trk_cmd   = b;
				trk_sum   = trk_sum + b;
				trk_state = ST_LEN;
			end
			ST_LEN: begin
				trk_len   = b;
				trk_sum   = trk_sum + b;
				trk_count = '0;
				trk_state = (b == 8'd0) ? ST_CHECK : ST_DATA;
			end
			ST_DATA: begin
				trk_sum         = trk_sum + b;
				r.result_kind   = KIND_PAYLOAD;
				r.payload_byte  = b;
				r.payload_index = trk_count;
				trk_count       = trk_count + 8'd1;
				if (trk_count == trk_len)
					trk_state = ST_CHECK;
				pending_results.push_back(r);
			end
			ST_CHECK: begin
				trk_sum          = trk_sum + b;
				r.result_kind    = KIND_VERDICT;
				r.subsystem      = trk_sub;
				r.command_code   = trk_cmd;
				r.payload_length = trk_len;
				r.checksum_ok    = (trk_sum == SUM_GOOD);
				trk_state        = ST_IDLE;
				pending_results.push_back(r);
			end
			default: trk_state = ST_IDLE;
		endcase
	endfunction

	function automatic string res_text(input res_t r);
		return $sformatf("kind=%0d byte=%02h idx=%0d sub=%02h cmd=%02h len=%0d ok=%0d",
			r.result_kind, r.payload_byte, r.payload_index, r.subsystem,
			r.command_code, r.payload_length, r.checksum_ok);
	endfunction

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// one word on the byte channel; valid stays high when no gap follows
	task automatic send_word(input logic [7:0] b, input logic s);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			byte_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_bus.valid       <= 1'b1;
		byte_bus.rx_byte     <= b;
		byte_bus.frame_start <= s;
		do @(posedge clk); while (!(byte_bus.valid && byte_bus.ready));
		deframe_byte(b, s);
		words_sent++;
	endtask

	task automatic send_seq(input logic [7:0] words[$], input bit flag_first);
		foreach (words[i])
			send_word(words[i], flag_first && (i == 0));
	endtask

	task automatic send_junk(input int n);
		repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// subsystem, command, length, data and sum; fill < 0 gives random data
	function automatic void build_body(input logic [7:0] sub, input logic [7:0] cmd,
		input logic [7:0] len, input bit good, input int fill, ref logic [7:0] q[$]);
		logic [7:0] s;
		logic [7:0] b;
		logic [7:0] chk;
		q.push_back(sub);
		q.push_back(cmd);
		q.push_back(len);
		s = sub + cmd + len;
		for (int i = 0; i < len; i++) begin
			b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
			q.push_back(b);
			s = s + b;
		end
		chk = 8'hFF - s;
		if (!good)
			chk = chk + 8'($urandom_range(1, 255));
		q.push_back(chk);
	endfunction

	// full buffer at the current offset; cut > 0 keeps only that many words
	task automatic send_frame(input logic [7:0] sub, input logic [7:0] cmd,
		input logic [7:0] len, input bit good, input int cut, input int fill);
		logic [7:0] words[$];
		repeat (trk_offset) words.push_back(8'($urandom_range(0, 255)));
		build_body(sub, cmd, len, good, fill, words);
		if (cut > 0)
			while (words.size() > cut) void'(words.pop_back());
		send_seq(words, 1'b1);
	endtask

	// sender holds off until every expected result is back
	task automatic settle();
		byte_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(input logic [7:0] v);
		cfg_bus.valid         <= 1'b1;
		cfg_bus.header_offset <= v;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		cfg_bus.valid <= 1'b0;
		trk_offset = v;
		settings_used++;
	endtask

	task automatic random_frame();
		logic [7:0] len;
		int cut;
		len = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(7, 255))
			: 8'($urandom_range(0, 6));
		cut = -1;
		if ($urandom_range(0, 9) == 0)
			cut = $urandom_range(1, int'(trk_offset) + 3 + int'(len));
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
			$urandom_range(0, 4) != 0, cut, -1);
		if ($urandom_range(0, 6) == 0)
			send_junk($urandom_range(1, 3));
		if ($urandom_range(0, 49) == 0)
			settle();
	endtask

	// ---- tests ----

	task automatic test_idle_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h5C, 1'b0);
	endtask

	task automatic test_reset_offset();
		send_frame(8'hA5, 8'h5A, 8'd1, 1'b1, -1, -1);
	endtask

	task automatic test_zero_offset();
		settle();
		write_offset(8'd0);
		send_frame(8'hFF, 8'h00, 8'd0, 1'b1, -1, -1);
		send_frame(8'h00, 8'hFF, 8'd2, 1'b0, -1, 8'hFF);
		send_junk(2);
		send_frame(8'h12, 8'h34, 8'd1, 1'b1, -1, 8'h00);
	endtask

	task automatic test_restart_mid_frame();
		send_frame(8'h11, 8'h22, 8'd3, 1'b1, 4, -1);
		send_frame(8'h33, 8'h44, 8'd1, 1'b1, -1, -1);
		settle();
		write_offset(8'd2);
		send_frame(8'h55, 8'h66, 8'd0, 1'b1, 1, -1);
		send_frame(8'h77, 8'h88, 8'd1, 1'b0, -1, -1);
	endtask

	task automatic test_offset_rewrite_mid_header();
		logic [7:0] body[$];
		// new offset already passed by the skipped count
		settle();
		write_offset(8'd20);
		repeat (10) body.push_back(8'($urandom_range(0, 255)));
		send_seq(body, 1'b1);
		settle();
		write_offset(8'd5);
		body.delete();
		body.push_back(8'($urandom_range(0, 255)));
		build_body(8'h9A, 8'hBC, 8'd2, 1'b1, -1, body);
		send_seq(body, 1'b0);
		// new offset reached exactly
		settle();
		write_offset(8'd12);
		body.delete();
		repeat (4) body.push_back(8'($urandom_range(0, 255)));
		send_seq(body, 1'b1);
		settle();
		write_offset(8'd6);
		body.delete();
		repeat (2) body.push_back(8'($urandom_range(0, 255)));
		build_body(8'hDE, 8'hF0, 8'd1, 1'b1, -1, body);
		send_seq(body, 1'b0);
	endtask

	task automatic test_max_sizes();
		settle();
		write_offset(8'd255);
		send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255,
			1'b1, -1, -1);
	endtask

	task automatic test_random_traffic(input int target);
		int base;
		int phase_base;
		int step;
		logic [7:0] offs;
		base = words_sent;
		step = 0;
		while (words_sent - base < target) begin
			settle();
			case (step)
				0: offs = 8'd0;
				1: offs = 8'd1;
				2: offs = 8'd255;
				3: offs = HDR_OFFSET_RST;
				default: offs = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 24));
			endcase
			write_offset(offs);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			phase_base = words_sent;
			while (words_sent - phase_base < 150 && words_sent - base < target)
				random_frame();
			step++;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// ---- result checking ----

	initial begin
		int unsigned stall;
		res_t got;
		res_t exp;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
			got.result_kind    = res_bus.result_kind;
			got.payload_byte   = res_bus.payload_byte;
			got.payload_index  = res_bus.payload_index;
			got.subsystem      = res_bus.subsystem;
			got.command_code   = res_bus.command_code;
			got.payload_length = res_bus.payload_length;
			got.checksum_ok    = res_bus.checksum_ok;
			if (pending_results.size() == 0) begin
				note_fail({"result with nothing expected: ", res_text(got)});
			end else begin
				exp = pending_results.pop_front();
				if (exp.result_kind == KIND_VERDICT) begin
					verdicts_seen++;
					if (exp.checksum_ok)
						good_verdicts++;
				end else begin
					payload_seen++;
				end
				if (got.result_kind !== exp.result_kind
						|| got.payload_byte !== exp.payload_byte
						|| got.payload_index !== exp.payload_index
						|| got.subsystem !== exp.subsystem
						|| got.command_code !== exp.command_code
						|| got.payload_length !== exp.payload_length
						|| got.checksum_ok !== exp.checksum_ok)
					note_fail({"mismatch\n  exp ", res_text(exp), "\n  got ", res_text(got)});
			end
		end
	end

	// ends the run when no word moves on any channel for too long
	always @(posedge clk) begin
		if ((cfg_bus.valid && cfg_bus.ready) || (byte_bus.valid && byte_bus.ready)
				|| (res_bus.valid && res_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_results.size());
			$display("packet_deframer_sum_check_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---- sequence ----

	initial begin
		trk_offset = HDR_OFFSET_RST;
		trk_state  = ST_IDLE;
		trk_count  = '0;
		trk_sum    = '0;
		trk_sub    = '0;
		trk_cmd    = '0;
		trk_len    = '0;
		arst_n                <= 1'b0;
		byte_bus.valid        <= 1'b0;
		byte_bus.rx_byte      <= '0;
		byte_bus.frame_start  <= 1'b0;
		cfg_bus.valid         <= 1'b0;
		cfg_bus.header_offset <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_bytes();
		test_reset_offset();
		test_zero_offset();
		test_restart_mid_frame();
		test_offset_rewrite_mid_header();
		test_max_sizes();
		test_random_traffic(RANDOM_WORDS);

		settle();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			note_fail($sformatf("%0d expected results never arrived", pending_results.size()));

		$display("Sent %0d byte words over %0d offset settings (0 to 255).",
			words_sent, settings_used);
		$display("Checked %0d payload words and %0d verdicts, %0d with a good sum; %0d failures.",
			payload_seen, verdicts_seen, good_verdicts, fail_count);
		if (fail_count == 0)
			$display("packet_deframer_sum_check_tb OK");
		else
			$display("packet_deframer_sum_check_tb NOT OK");
		$finish;
	end

endmodule
